// ===== hw/rtl/nla_pkg.sv =====
// Shared constants and types for the newline line assembler.
package nla_pkg;

	localparam int LINE_BYTES_DEF = 64;
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 16;
	localparam int CFG_W          = 16;
	localparam int PDATA_W        = 32;
	localparam int PADDR_W        = 3;

	localparam logic [BYTE_W-1:0]  BYTE_CR      = 8'd13;
	localparam logic [BYTE_W-1:0]  BYTE_LF      = 8'd10;
	localparam logic [CFG_W-1:0]   OUT_SIZE_RST = 16'd64;
	localparam logic [PADDR_W-1:0] ADDR_OUT_SIZE = 3'd0;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} nla_state_t;

endpackage

// ===== hw/rtl/nla_if.sv =====
// Valid/ready channel interfaces for received bytes and delivered line beats.
interface nla_rx_if import nla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nla_line_if import nla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              byte_valid;
	logic              last;
	logic              truncated;
	logic [CNT_W-1:0]  overflow_lines;
	logic [CNT_W-1:0]  discarded_lines;
	logic [CNT_W-1:0]  truncated_lines;

	modport source (output valid, output data_byte, output byte_valid, output last,
		output truncated, output overflow_lines, output discarded_lines,
		output truncated_lines, input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last,
		input truncated, input overflow_lines, input discarded_lines,
		input truncated_lines, output ready);
endinterface

// ===== hw/rtl/newline_line_assembler.sv =====
// Newline line assembler: line store, read-out sequencer and APB register.
// Read-out: a newline that ends a stored line shows the first line beat in the cycle after it is
// accepted, then one beat per cycle while the sink is ready.
// Throughput: one byte per cycle while rx ready is high; such a newline holds rx ready low
// until the last beat of its line is taken (up to LINE_BYTES-1 beats).
// Reset: length, discard flag and counters clear, out_size returns to 64; store is not cleared.
module newline_line_assembler import nla_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	nla_rx_if.sink              rx,
	nla_line_if.source          line,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

	logic [BYTE_W-1:0] store_q [LINE_BYTES];

	nla_state_t        state_q;
	logic [LEN_W-1:0]  len_q;
	logic              discarding_q;
	logic [CNT_W-1:0]  ovf_cnt_q;
	logic [CNT_W-1:0]  disc_cnt_q;
	logic [CNT_W-1:0]  trunc_cnt_q;
	logic [CFG_W-1:0]  out_size_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  last_idx_q;
	logic              byte_valid_q;
	logic              trunc_q;
	logic [BYTE_W-1:0] rd_data_q;

	logic              rx_beat;
	logic              out_beat;
	logic              is_cr;
	logic              is_lf;
	logic              cfg_hit;
	logic [CFG_W-1:0]  limit;
	logic [CFG_W-1:0]  len_ext;
	logic              cut;
	logic [LEN_W-1:0]  n_bytes;
	logic              start_line;
	logic              store_wr;
	logic              rd_en;
	logic [LEN_W-1:0]  rd_addr;
	logic              last_beat;

	assign rx_beat  = rx.valid && rx.ready;
	assign out_beat = line.valid && line.ready;
	assign is_cr    = (rx.rx_byte == BYTE_CR);
	assign is_lf    = (rx.rx_byte == BYTE_LF);
	assign cfg_hit  = (paddr == ADDR_OUT_SIZE);

	assign limit   = (out_size_q == '0) ? '0 : out_size_q - CFG_W'(1);
	assign len_ext = {{(CFG_W-LEN_W){1'b0}}, len_q};
	assign cut     = (len_ext > limit);
	assign n_bytes = cut ? limit[LEN_W-1:0] : len_q;

	assign start_line = rx_beat && !is_cr && !discarding_q && is_lf && (len_q != '0);
	assign store_wr   = rx_beat && !is_cr && !discarding_q && !is_lf && (len_q < LEN_MAX);
	assign last_beat  = !byte_valid_q || (idx_q == last_idx_q);
	assign rd_en      = start_line || (out_beat && !last_beat);
	assign rd_addr    = (state_q == ST_IDLE) ? '0 : idx_q + LEN_W'(1);

	assign rx.ready             = (state_q == ST_IDLE);
	assign line.valid           = (state_q == ST_SEND);
	assign line.data_byte       = byte_valid_q ? rd_data_q : '0;
	assign line.byte_valid      = byte_valid_q;
	assign line.last            = last_beat;
	assign line.truncated       = trunc_q;
	assign line.overflow_lines  = ovf_cnt_q;
	assign line.discarded_lines = disc_cnt_q;
	assign line.truncated_lines = trunc_cnt_q;

	assign pready = 1'b1;
	assign prdata = cfg_hit ? {{(PDATA_W-CFG_W){1'b0}}, out_size_q} : '0;

	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_q[len_q] <= rx.rx_byte;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_line) begin
			last_idx_q   <= n_bytes - LEN_W'(1);
			byte_valid_q <= (n_bytes != '0);
			trunc_q      <= cut;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_size_q <= OUT_SIZE_RST;
		end else if (psel && penable && pwrite && cfg_hit) begin
			out_size_q <= pwdata[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			discarding_q <= 1'b0;
			ovf_cnt_q    <= '0;
			disc_cnt_q   <= '0;
			trunc_cnt_q  <= '0;
			idx_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rx_beat && !is_cr) begin
						if (discarding_q) begin
							if (is_lf) begin
								discarding_q <= 1'b0;
								len_q        <= '0;
								disc_cnt_q   <= disc_cnt_q + CNT_W'(1);
							end
						end else if (is_lf) begin
							if (len_q != '0) begin
								len_q   <= '0;
								idx_q   <= '0;
								state_q <= ST_SEND;
								if (cut) begin
									trunc_cnt_q <= trunc_cnt_q + CNT_W'(1);
								end
							end
						end else if (len_q < LEN_MAX) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							len_q        <= '0;
							discarding_q <= 1'b1;
							ovf_cnt_q    <= ovf_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_SEND: begin
					if (out_beat) begin
						if (last_beat) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + LEN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx.ready && line.valid))
		else $error("rx ready while a line beat is pending");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && line.last) |=> rx.ready)
		else $error("rx not ready after last beat of a line");

	a_line_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_beat && is_lf && !discarding_q && (len_q != '0)) |=> line.valid)
		else $error("newline ending a stored line did not start a run");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q <= LEN_MAX))
		else $error("line length beyond store capacity");

endmodule

// ===== bench/nla_line_checker.sv =====
// Checker: watches the byte and line channels and the APB port, predicts line beats and compares.
module nla_line_checker import nla_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	input  logic               rx_ready,
	input  logic [BYTE_W-1:0]  rx_byte,
	input  logic               line_valid,
	input  logic               line_ready,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               byte_valid,
	input  logic               last,
	input  logic               truncated,
	input  logic [CNT_W-1:0]   overflow_lines,
	input  logic [CNT_W-1:0]   discarded_lines,
	input  logic [CNT_W-1:0]   truncated_lines,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 pending_beats,
	output int                 fail_count
);

	localparam int IDX_W = $clog2(LINE_BYTES);

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              last;
		logic              truncated;
		logic [CNT_W-1:0]  overflow_lines;
		logic [CNT_W-1:0]  discarded_lines;
		logic [CNT_W-1:0]  truncated_lines;
	} line_beat_t;

	line_beat_t        line_beats_q[$];
	logic [BYTE_W-1:0] line_mem [LINE_BYTES];
	int unsigned       fill_len;
	logic              dropping;
	logic [CNT_W-1:0]  ovf_cnt;
	logic [CNT_W-1:0]  disc_cnt;
	logic [CNT_W-1:0]  trunc_cnt;
	logic [CFG_W-1:0]  size_reg;

	task automatic push_beat(input logic [BYTE_W-1:0] d, input logic bv, input logic lst,
		input logic cut);
		line_beat_t beat;
		beat = {d, bv, lst, cut, ovf_cnt, disc_cnt, trunc_cnt};
		line_beats_q.push_back(beat);
	endtask

	task automatic frame_rx_byte(input logic [BYTE_W-1:0] b);
		int unsigned keep;
		int unsigned keep_max;
		logic        cut;
		if (b != BYTE_CR) begin
			if (dropping) begin
				if (b == BYTE_LF) begin
					dropping = 1'b0;
					fill_len = 0;
					disc_cnt = disc_cnt + 1'b1;
				end
			end else if (b == BYTE_LF) begin
				if (fill_len != 0) begin
					keep_max = (size_reg == '0) ? 0 : size_reg - 1;
					keep = fill_len;
					cut = 1'b0;
					if (keep > keep_max) begin
						keep = keep_max;
						cut = 1'b1;
						trunc_cnt = trunc_cnt + 1'b1;
					end
					fill_len = 0;
					if (keep == 0)
						push_beat('0, 1'b0, 1'b1, cut);
					else
						for (int i = 0; i < keep; i++)
							push_beat(line_mem[IDX_W'(i)], 1'b1, (i == keep - 1), cut);
				end
			end else if (fill_len < LINE_BYTES - 1) begin
				line_mem[IDX_W'(fill_len)] = b;
				fill_len++;
			end else begin
				fill_len = 0;
				dropping = 1'b1;
				ovf_cnt = ovf_cnt + 1'b1;
			end
		end
	endtask

	task automatic check_line_beat();
		line_beat_t got;
		line_beat_t want;
		got = {data_byte, byte_valid, last, truncated, overflow_lines, discarded_lines,
			truncated_lines};
		if (line_beats_q.size() == 0) begin
			if (fail_count < 10)
				$display("%0t: unexpected line beat data=%02h bv=%0b last=%0b trunc=%0b",
					$realtime, got.data_byte, got.byte_valid, got.last, got.truncated);
			fail_count++;
		end else begin
			want = line_beats_q.pop_front();
			if (got !== want) begin
				if (fail_count < 10) begin
					$display("%0t: beat mismatch exp data=%02h bv=%0b last=%0b trunc=%0b cnt=%0d/%0d/%0d",
						$realtime, want.data_byte, want.byte_valid, want.last, want.truncated,
						want.overflow_lines, want.discarded_lines, want.truncated_lines);
					$display("%0t:                got data=%02h bv=%0b last=%0b trunc=%0b cnt=%0d/%0d/%0d",
						$realtime, got.data_byte, got.byte_valid, got.last, got.truncated,
						got.overflow_lines, got.discarded_lines, got.truncated_lines);
				end
				fail_count++;
			end
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_beats_q.delete();
			fill_len = 0;
			dropping = 1'b0;
			ovf_cnt = '0;
			disc_cnt = '0;
			trunc_cnt = '0;
			size_reg = OUT_SIZE_RST;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_OUT_SIZE)
				size_reg = pwdata[CFG_W-1:0];
			if (line_valid && line_ready)
				check_line_beat();
			if (rx_valid && rx_ready)
				frame_rx_byte(rx_byte);
		end
		pending_beats <= line_beats_q.size();
	end

endmodule

// ===== bench/newline_line_assembler_tb.sv =====
// Testbench top: clock, reset, byte and APB stimulus, line-side stalls and the final verdict.
module newline_line_assembler_tb;
	import nla_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_SPARE = 3'd4;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 pending_beats;
	int                 fail_count;
	int                 idle_pct;
	int                 stall_pct;
	int                 bytes_sent;

	nla_rx_if   rx_ch ();
	nla_line_if line_ch ();

	newline_line_assembler u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.line    (line_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	nla_line_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_ch.valid),
		.rx_ready        (rx_ch.ready),
		.rx_byte         (rx_ch.rx_byte),
		.line_valid      (line_ch.valid),
		.line_ready      (line_ch.ready),
		.data_byte       (line_ch.data_byte),
		.byte_valid      (line_ch.byte_valid),
		.last            (line_ch.last),
		.truncated       (line_ch.truncated),
		.overflow_lines  (line_ch.overflow_lines),
		.discarded_lines (line_ch.discarded_lines),
		.truncated_lines (line_ch.truncated_lines),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pending_beats   (pending_beats),
		.fail_count      (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		line_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			line_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic drain_lines();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
	endtask

	task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
		drain_lines();
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_random_line();
		int                kind;
		int                len;
		logic [BYTE_W-1:0] b;
		kind = $urandom_range(99);
		if (kind < 70)
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 62) : $urandom_range(0, 12);
		else if (kind < 80)
			len = $urandom_range(62, 64);
		else if (kind < 88)
			len = $urandom_range(65, 80);
		else
			len = -1;
		if (len >= 0) begin
			for (int k = 0; k < len; k++) begin
				b = BYTE_W'($urandom_range(255));
				while (b == BYTE_LF)
					b = BYTE_W'($urandom_range(255));
				send_byte(b);
			end
			send_byte(BYTE_LF);
		end else begin
			len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(3))
					0: begin
						b = BYTE_LF;
					end
					1: begin
						b = BYTE_CR;
					end
					default: begin
						b = BYTE_W'($urandom_range(255));
					end
				endcase
				send_byte(b);
			end
		end
	endtask

	initial begin
		int phase_end;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(BYTE_LF);
		send_byte(BYTE_CR);
		send_byte(BYTE_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(BYTE_CR);
		send_byte(8'h41);
		send_byte(BYTE_LF);
		program_reg(ADDR_OUT_SIZE, 32'd1);
		send_byte(8'h55);
		send_byte(BYTE_LF);
		program_reg(ADDR_OUT_SIZE, 32'd0);
		send_byte(8'hAA);
		send_byte(8'h01);
		send_byte(BYTE_LF);
		program_reg(ADDR_OUT_SIZE, 32'd3);
		for (int k = 0; k < 5; k++)
			send_byte(BYTE_W'(8'h30 + k));
		send_byte(BYTE_LF);
		program_reg(ADDR_SPARE, 32'd2);
		send_byte(8'h7E);
		send_byte(8'h80);
		send_byte(8'h61);
		send_byte(BYTE_LF);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					program_reg(ADDR_OUT_SIZE, {16'h0000, OUT_SIZE_RST});
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					program_reg(ADDR_OUT_SIZE, 32'hA5A5_FFFF);
					idle_pct = 77;
					stall_pct = 0;
				end
				2: begin
					program_reg(ADDR_OUT_SIZE, $urandom_range(2, 24));
					idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					program_reg(ADDR_OUT_SIZE, $urandom_range(25, 70));
					idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			phase_end = bytes_sent + 120;
			while (bytes_sent < phase_end)
				send_random_line();
		end

		drain_lines();
		repeat (70) @(posedge clk);
		if (fail_count == 0 && pending_beats == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
